// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset gating
`define SDRLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SDRLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sdrle_pkg.sv =====
package sdrle_pkg;

  localparam int unsigned SECTOR_BYTES = 256;
  localparam logic [7:0]  LAST_POS     = 8'(SECTOR_BYTES - 1);
  localparam logic [7:0]  END_WRAP     = 8'(SECTOR_BYTES);
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    KIND_DELTA     = 3'd0,
    KIND_RUN_START = 3'd1,
    KIND_RUN_END   = 3'd2,
    KIND_CRC_LO    = 3'd3,
    KIND_CRC_HI    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } entry_t;

  // words caused by one input byte, entries 0..last_idx are valid
  typedef struct packed {
    logic [1:0]       last_idx;
    entry_t [3:0]     ent;
  } plan_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/sdrle_queue.sv =====
module sdrle_queue
  import sdrle_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  plan_t wr_plan_i,
  output logic  full_o,
  input  logic  rd_i,
  output plan_t rd_plan_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  plan_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_plan_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_plan_i;
    end
  end

endmodule

// ===== hdl/sdrle_front.sv =====
module sdrle_front
  import sdrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [7:0] sector_byte_i,
  output logic       full,
  output logic       q_wr_o,
  output plan_t      q_plan_o,
  input  logic       q_full_i
);

  logic [7:0]  prev_q, prev_d;
  logic        run_q, run_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  delta;
  logic [2:0]  n;
  logic        accept;
  plan_t       plan;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  always_comb begin
    plan   = '0;
    n      = '0;
    run_d  = run_q;
    prev_d = sector_byte_i;
    pos_d  = pos_q + 8'd1;
    crc_d  = crc_step(crc_q, sector_byte_i);
    delta  = sector_byte_i - prev_q;
    // run broken by a different byte
    if (run_q && (sector_byte_i != prev_q)) begin
      plan.ent[n[1:0]] = '{data: pos_q, kind: KIND_RUN_END};
      n     = n + 3'd1;
      run_d = 1'b0;
    end
    if (!run_d) begin
      if (delta == 8'd0) begin
        plan.ent[n[1:0]] = '{data: 8'd0, kind: KIND_RUN_START};
        run_d = 1'b1;
      end else begin
        plan.ent[n[1:0]] = '{data: delta, kind: KIND_DELTA};
      end
      n = n + 3'd1;
    end
    // sector end
    if (pos_q == LAST_POS) begin
      if (run_d) begin
        plan.ent[n[1:0]] = '{data: END_WRAP, kind: KIND_RUN_END};
        n = n + 3'd1;
      end
      plan.ent[n[1:0]] = '{data: crc_d[7:0], kind: KIND_CRC_LO};
      n = n + 3'd1;
      plan.ent[n[1:0]] = '{data: crc_d[15:8], kind: KIND_CRC_HI};
      n = n + 3'd1;
      run_d  = 1'b0;
      prev_d = '0;
      pos_d  = '0;
      crc_d  = '0;
    end
    plan.last_idx = 2'(n - 3'd1);
  end

  assign q_wr_o   = accept && (n != 3'd0);
  assign q_plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      run_q  <= 1'b0;
      pos_q  <= '0;
      crc_q  <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
      run_q  <= run_d;
      pos_q  <= pos_d;
      crc_q  <= crc_d;
    end
  end

endmodule

// ===== hdl/sdrle_back.sv =====
module sdrle_back
  import sdrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  plan_t      q_plan_i,
  input  logic       q_empty_i,
  output logic       q_rd_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_kind_o,
  output logic       last_of_run_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q;
  logic [7:0] data_q;
  kind_e      kind_q;
  logic       last_q;
  logic       load, take, at_end;

  assign load   = !vld_q || pop;
  assign take   = load && !q_empty_i;
  assign at_end = (idx_q == q_plan_i.last_idx);
  assign q_rd_o = take && at_end;
  assign idx_d  = at_end ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (take) begin
      vld_q <= 1'b1;
      idx_q <= idx_d;
    end else if (pop) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= q_plan_i.ent[idx_q].data;
      kind_q <= q_plan_i.ent[idx_q].kind;
      last_q <= at_end;
    end
  end

  assign empty         = !vld_q;
  assign out_byte_o    = data_q;
  assign out_kind_o    = kind_q;
  assign last_of_run_o = last_q;

endmodule

// ===== hdl/sector_delta_rle_encoder_crc16.sv =====
// Delta / run-length encoder for 256-byte sectors with trailing CRC-16 (poly 0x1021, init 0,
// msb first, low byte sent first). One byte is accepted per cycle while full is low: the front
// end does the delta, run tracking and one CRC byte step in that cycle and queues the words the
// byte causes (none to four) in a four-entry queue. The back end hands out one word per cycle
// through a registered output while pop is high or the output is empty, so the words of one
// byte leave one by one and full only rises once the queue has filled. A word reaches the
// output by way of the queue memory and then the output register. The position counter,
// previous value and CRC return to zero after the last byte of every sector.
module sector_delta_rle_encoder_crc16
  import sdrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] sector_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_kind_o,
  output logic       last_of_run_o
);

  logic  q_wr, q_full, q_rd, q_empty;
  plan_t q_wr_plan, q_rd_plan;

  sdrle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .sector_byte_i (sector_byte_i),
    .full          (full),
    .q_wr_o        (q_wr),
    .q_plan_o      (q_wr_plan),
    .q_full_i      (q_full)
  );

  sdrle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_plan_i (q_wr_plan),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_plan_o (q_rd_plan),
    .empty_o   (q_empty)
  );

  sdrle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_plan_i      (q_rd_plan),
    .q_empty_i     (q_empty),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .out_kind_o    (out_kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hdl/sdrle_checker.sv =====
`include "assert_macros.svh"

module sdrle_checker
  import sdrle_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic [2:0] out_kind_o,
  input logic       last_of_run_o
);

  `SDRLE_ASSERT(a_kind_legal, clk_i, rst_ni, !empty |-> (out_kind_o <= KIND_CRC_HI), "bad kind")
  `SDRLE_ASSERT(a_hold, clk_i, rst_ni,
    (!empty && !pop) |=> (!empty && $stable({out_byte_o, out_kind_o, last_of_run_o})),
    "stalled word changed")
  `SDRLE_ASSERT(a_crc_pair, clk_i, rst_ni,
    (!empty && pop && out_kind_o == KIND_CRC_LO) |=> (!empty && out_kind_o == KIND_CRC_HI),
    "crc high does not follow crc low")
  `SDRLE_ASSERT(a_crc_last, clk_i, rst_ni,
    (!empty && out_kind_o == KIND_CRC_HI) |-> last_of_run_o, "crc high must close the byte")
  `SDRLE_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty, "words shown during reset")

endmodule

bind sector_delta_rle_encoder_crc16 sdrle_checker u_sdrle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_byte_o    (out_byte_o),
  .out_kind_o    (out_kind_o),
  .last_of_run_o (last_of_run_o)
);

// ===== test/sdrle_checker.sv =====
module sdrle_tb_checker
  import sdrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] sector_byte_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_byte_i,
  input  logic [2:0] out_kind_i,
  input  logic       last_of_run_i,
  output int         errors_o,
  output int         words_left_o,
  output int         words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    logic       is_last;
  } word_t;

  word_t      pending_words[$];
  logic [7:0] prev_val;
  logic       run_open;
  logic [7:0] sector_pos;
  logic [15:0] crc_acc;
  int         error_total;
  int         checked_total;

  function automatic logic [15:0] crc_shift(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  task automatic encode_sector_byte(input logic [7:0] b);
    word_t      caused[$];
    logic [7:0] diff;
    crc_acc = crc_shift(crc_acc, b);
    if (run_open && b != prev_val) begin
      caused.push_back('{data: sector_pos, kind: KIND_RUN_END, is_last: 1'b0});
      run_open = 1'b0;
    end
    if (!run_open) begin
      diff = b - prev_val;
      if (diff == 8'h00) begin
        caused.push_back('{data: 8'h00, kind: KIND_RUN_START, is_last: 1'b0});
        run_open = 1'b1;
      end else begin
        caused.push_back('{data: diff, kind: KIND_DELTA, is_last: 1'b0});
      end
    end
    prev_val = b;
    if (sector_pos == LAST_POS) begin
      if (run_open) begin
        caused.push_back('{data: END_WRAP, kind: KIND_RUN_END, is_last: 1'b0});
      end
      caused.push_back('{data: crc_acc[7:0], kind: KIND_CRC_LO, is_last: 1'b0});
      caused.push_back('{data: crc_acc[15:8], kind: KIND_CRC_HI, is_last: 1'b0});
      prev_val   = 8'h00;
      run_open   = 1'b0;
      sector_pos = 8'h00;
      crc_acc    = 16'h0000;
    end else begin
      sector_pos = sector_pos + 8'd1;
    end
    if (caused.size() > 0) caused[caused.size() - 1].is_last = 1'b1;
    foreach (caused[i]) pending_words.push_back(caused[i]);
  endtask

  task automatic check_word();
    word_t want;
    if (pending_words.size() == 0) begin
      if (error_total < 10) begin
        $display("unexpected word: byte %02h kind %0d last %0b",
                 out_byte_i, out_kind_i, last_of_run_i);
      end
      error_total++;
    end else begin
      want = pending_words.pop_front();
      if (out_byte_i !== want.data || out_kind_i !== want.kind ||
          last_of_run_i !== want.is_last) begin
        if (error_total < 10) begin
          $display("word %0d mismatch: expected byte %02h kind %0d last %0b",
                   checked_total, want.data, want.kind, want.is_last);
          $display("  got byte %02h kind %0d last %0b",
                   out_byte_i, out_kind_i, last_of_run_i);
        end
        error_total++;
      end
    end
    checked_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_words.delete();
      prev_val        = 8'h00;
      run_open        = 1'b0;
      sector_pos      = 8'h00;
      crc_acc         = 16'h0000;
      error_total     = 0;
      checked_total   = 0;
      errors_o        <= 0;
      words_left_o    <= 0;
      words_checked_o <= 0;
    end else begin
      if (push_i && !full_i) encode_sector_byte(sector_byte_i);
      if (pop_i && !empty_i) check_word();
      errors_o        <= error_total;
      words_left_o    <= pending_words.size();
      words_checked_o <= checked_total;
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import sdrle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BYTES  = 420;
  localparam int PAUSE_AT     = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  // opening bytes: extremes, runs opened at sector start, runs broken, wraparound deltas
  localparam logic [191:0] OPENING =
    192'h000000FF_00807F01_FE55AAAA_AAAA5454_55FFFF00_0100FFFE;

  logic       clk_i;
  logic       rst_ni;
  logic       push        = 1'b0;
  logic [7:0] sector_byte = 8'h00;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       last_of_run;
  int         error_count;
  int         words_left;
  int         words_checked;
  int unsigned cycle_count = 0;
  logic [7:0] sector_stream[$];

  sector_delta_rle_encoder_crc16 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sector_byte_i (sector_byte),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte),
    .out_kind_o    (out_kind),
    .last_of_run_o (last_of_run)
  );

  sdrle_tb_checker word_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .sector_byte_i   (sector_byte),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_byte_i      (out_byte),
    .out_kind_i      (out_kind),
    .last_of_run_i   (last_of_run),
    .errors_o        (error_count),
    .words_left_o    (words_left),
    .words_checked_o (words_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sector_delta_rle_encoder_crc16 test failed");
      $finish;
    end
  end

  task automatic build_stream();
    logic [7:0] run_val;
    int         run_len;
    int         fill_end;
    for (int i = 0; i < 24; i++) sector_stream.push_back(OPENING[191 - 8 * i -: 8]);
    for (int s = 0; s < 2; s++) begin
      // the second sector starts with zero so a stale previous value shows up
      if (s > 0) sector_stream.push_back(8'h00);
      fill_end = (s == 0) ? int'(SECTOR_BYTES) - 4 : TOTAL_BYTES;
      while (sector_stream.size() < fill_end) begin
        if ($urandom_range(0, 2) == 0) begin
          run_val = 8'($urandom_range(0, 255));
          run_len = $urandom_range(2, 10);
          repeat (run_len) begin
            if (sector_stream.size() < fill_end) sector_stream.push_back(run_val);
          end
        end else begin
          sector_stream.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (s == 0) begin
        // run broken next to the end, last byte opens a run
        repeat (2) sector_stream.push_back(8'h3C);
        repeat (2) sector_stream.push_back(8'h66);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    push        <= 1'b1;
    sector_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    int span;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 40);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            pop <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            pop <= (c % 3 != 2);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int idx;
    int burst;
    rst_ni <= 1'b0;
    build_stream();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idx = 0;
    while (idx < sector_stream.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && idx < sector_stream.size()) begin
        if (idx == PAUSE_AT) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (words_left != 0) @(posedge clk_i);
        end
        send_byte(sector_stream[idx]);
        idx++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    push <= 1'b0;
    @(posedge clk_i);
    while (words_left != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d bytes: one full sector and part of the next (extremes, runs, tail)",
             sector_stream.size());
    $display("checked %0d output words, %0d mismatches", words_checked, error_count);
    if (error_count == 0) begin
      $display("sector_delta_rle_encoder_crc16 test passed");
    end else begin
      $display("sector_delta_rle_encoder_crc16 test failed");
    end
    $finish;
  end

endmodule
